### rtl/srd_pkg.sv
// Shared constants, types and the run settle function of the sprite row decoder.
package srd_pkg;

   // Configuration register map (word index taken from csr_paddr[2]).
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic [7:0] WIDTH_RESET  = 8'd1;
   localparam logic [7:0] HEIGHT_RESET = 8'd1;

   localparam int COUNT_BITS_DEFAULT = 24;

   // Result kinds carried on rsp_tuser.
   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Bit positions of the result fields inside rsp_tdata.
   localparam int IDX_LSB    = 0;
   localparam int COLOUR_LSB = 16;
   localparam int LEAK_BIT   = 24;
   localparam int END_BIT    = 25;
   localparam int COUNT_LSB  = 26;

   // Depth of the result queue; a power of two.
   localparam int RSP_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0]  row;
      logic [15:0] col;
      logic [6:0]  run;
      logic        leak;
      logic        done;
   } settle_type;

   // Resolves the run positions that consume no byte: a run that hits the
   // right edge is dropped, a column past the edge wraps to the next row,
   // and a run below the last row is dropped and ends the picture.
   function automatic settle_type settle(input logic [7:0]  row,
                                         input logic [15:0] col,
                                         input logic [6:0]  run,
                                         input logic [7:0]  width,
                                         input logic [7:0]  height);
      settle_type s;
      s.row  = row;
      s.col  = col;
      s.run  = run;
      s.leak = 1'b0;
      if (run != 7'd0) begin
         if (row >= height) begin
            s.leak = 1'b1;
            s.run  = 7'd0;
         end else if (col > {8'd0, width}) begin
            s.row  = row + 8'd1;
            s.col  = 16'd0;
            s.leak = 1'b1;
            s.run  = run - 7'd1;
            if (s.run != 7'd0) begin
               if (s.row >= height) begin
                  s.run = 7'd0;
               end else if (width == 8'd0) begin
                  s.run = 7'd0;
               end
            end
         end else if (col == {8'd0, width}) begin
            s.leak = 1'b1;
            s.run  = 7'd0;
         end
      end
      s.done = (s.run == 7'd0) && (s.row >= height);
      return s;
   endfunction

endpackage

### rtl/sprite_rle_row_decoder.sv
// Top level of the 8-bit sprite run-length decoder with its register port.
//
//   Channel   Direction  Carries
//   req_*     in         one code byte per word, with past-end and start flags
//   rsp_*     out        pixel writes and picture summaries, one per word
//   csr_*     in/out     picture width and height registers
//
// A code byte is taken into an input register, decoded against the picture
// state and its results written into a four-entry result queue. One word is
// accepted per cycle as long as the queue has room for two results; a word
// can yield both a pixel and a summary, and the result port drains one result
// a cycle, so the sustained rate is one word per cycle. Reset is synchronous
// and leaves the decoder waiting for a start word. A stall on rsp_tready
// fills the queue and then holds req_tready low.
module sprite_rle_row_decoder #(
   parameter int COUNT_BITS = srd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code_byte
   input  logic [1:0]  req_tuser,   // [0] past_end, [1] start_picture

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] pixel_index, [23:16] pixel_colour, [24] leak_error,
   // [25] buffer_end_error, [COUNT_BITS+25:26] bytes_used, zero fill above
   output logic [((srd_pkg::COUNT_LSB + COUNT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast,   // last_result

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DATA_W  = ((srd_pkg::COUNT_LSB + COUNT_BITS + 7) / 8) * 8;
   localparam int ENTRY_W = DATA_W + 2;

   // Configuration registers.
   logic [7:0] width_ff;
   logic [7:0] height_ff;
   logic       csr_write;
   logic       csr_sel_height;

   // Input register holding the word being decoded.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] code_ff;
   logic       past_ff;
   logic       start_ff;
   logic       req_accept;
   logic       consume;

   logic               space_ok;
   logic [1:0]         push_count;
   logic [ENTRY_W-1:0] push_a;
   logic [ENTRY_W-1:0] push_b;
   logic [ENTRY_W-1:0] rsp_entry;

   // The register word is picked by paddr[2]; the low address bits are not decoded.
   assign csr_pready     = 1'b1;
   assign csr_sel_height = (csr_paddr[2] == srd_pkg::REG_HEIGHT);
   assign csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata     = csr_sel_height ? {24'd0, height_ff} : {24'd0, width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= srd_pkg::WIDTH_RESET;
         height_ff <= srd_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         if (csr_sel_height) begin
            height_ff <= csr_pwdata[7:0];
         end else begin
            width_ff <= csr_pwdata[7:0];
         end
      end
   end

   // The held word is decoded when the queue can take both of its results;
   // a new word may enter in the same cycle.
   always_comb begin
      consume     = in_valid_ff && space_ok;
      req_tready  = !in_valid_ff || consume;
      req_accept  = req_tvalid && req_tready;
      in_valid_in = req_accept ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         code_ff  <= req_tdata;
         past_ff  <= req_tuser[0];
         start_ff <= req_tuser[1];
      end
   end

   srd_core #(
      .COUNT_BITS (COUNT_BITS),
      .DATA_W     (DATA_W)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .picture_width  (width_ff),
      .picture_height (height_ff),
      .code_byte      (code_ff),
      .past_end       (past_ff),
      .start_picture  (start_ff),
      .consume        (consume),
      .push_count     (push_count),
      .push_a         (push_a),
      .push_b         (push_b)
   );

   srd_rsp_queue #(
      .WIDTH (ENTRY_W)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (consume ? push_count : 2'd0),
      .push_a     (push_a),
      .push_b     (push_b),
      .space_ok   (space_ok),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_entry)
   );

   // Queue entries are {last, kind, data}.
   assign rsp_tdata = rsp_entry[DATA_W-1:0];
   assign rsp_tuser = rsp_entry[DATA_W];
   assign rsp_tlast = rsp_entry[DATA_W+1];

endmodule

### rtl/srd_core.sv
// Decoder state and the single-pass decode of one code byte into up to two results.
module srd_core #(
   parameter int COUNT_BITS = srd_pkg::COUNT_BITS_DEFAULT,
   parameter int DATA_W     = 56
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        picture_width,
   input  logic [7:0]        picture_height,
   input  logic [7:0]        code_byte,
   input  logic              past_end,
   input  logic              start_picture,
   input  logic              consume,
   output logic [1:0]        push_count,
   output logic [DATA_W+1:0] push_a,
   output logic [DATA_W+1:0] push_b
);

   logic [7:0]            row_ff, row_in;
   logic [15:0]           col_ff, col_in;
   logic [6:0]            run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  leak_ff, leak_in;
   logic                  end_ff, end_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   logic [7:0]            row_s;
   logic [15:0]           col_s;
   logic [6:0]            run_s;
   logic                  leak_s;
   logic                  end_s;
   logic [COUNT_BITS-1:0] cnt_s;
   logic                  active;
   logic                  start_done;
   logic                  process;
   logic [7:0]            byte_v;
   logic                  pixel;
   logic                  summary;
   logic [15:0]           pixel_index;
   logic [15:0]           row_base;
   srd_pkg::settle_type   st;
   logic [DATA_W-1:0]     pix_data;
   logic [DATA_W-1:0]     sum_data;

   always_comb begin
      // A new picture clears everything before its first byte is looked at.
      row_s  = start_picture ? 8'd0 : row_ff;
      col_s  = start_picture ? 16'd0 : col_ff;
      run_s  = start_picture ? 7'd0 : run_ff;
      leak_s = start_picture ? 1'b0 : leak_ff;
      end_s  = start_picture ? 1'b0 : end_ff;
      cnt_s  = start_picture ? '0 : cnt_ff;

      active     = start_picture || !done_ff;
      start_done = start_picture && (picture_height == 8'd0);
      process    = active && !start_done;
      byte_v     = past_end ? 8'd0 : code_byte;

      row_base    = {8'd0, picture_width} * {8'd0, row_s};
      pixel_index = row_base + col_s;

      row_in  = row_s;
      col_in  = col_s;
      run_in  = run_s;
      leak_in = leak_s;
      end_in  = end_s | past_end;
      done_in = 1'b0;
      cnt_in  = (cnt_s == '1) ? cnt_s : cnt_s + COUNT_BITS'(1);

      st = srd_pkg::settle(row_s, col_s, run_s, picture_width, picture_height);

      if (run_s != 7'd0) begin
         st = srd_pkg::settle(row_s, col_s + 16'd1, run_s - 7'd1,
                              picture_width, picture_height);
      end else if (byte_v[7]) begin
         // Skip: the magnitude of the negative byte is added to the column.
         st.row  = row_s;
         st.col  = col_s - {8'hFF, byte_v};
         st.run  = 7'd0;
         st.leak = 1'b0;
         st.done = 1'b0;
      end else if (byte_v == 8'd0) begin
         st = srd_pkg::settle(row_s + 8'd1, 16'd0, 7'd0,
                              picture_width, picture_height);
      end else begin
         st = srd_pkg::settle(row_s, col_s, byte_v[6:0],
                              picture_width, picture_height);
      end

      if (process) begin
         row_in  = st.row;
         col_in  = st.col;
         run_in  = st.run;
         leak_in = leak_s | st.leak;
         done_in = st.done;
      end else if (start_done) begin
         end_in  = 1'b0;
         cnt_in  = '0;
         done_in = 1'b1;
      end else begin
         // Idle bytes between pictures leave the state untouched.
         row_in  = row_ff;
         col_in  = col_ff;
         run_in  = run_ff;
         leak_in = leak_ff;
         end_in  = end_ff;
         cnt_in  = cnt_ff;
         done_in = done_ff;
      end

      pixel   = process && (run_s != 7'd0) && !past_end;
      summary = start_done || (process && st.done);

      pix_data = '0;
      pix_data[srd_pkg::IDX_LSB +: 16]   = pixel_index;
      pix_data[srd_pkg::COLOUR_LSB +: 8] = byte_v;

      sum_data = '0;
      sum_data[srd_pkg::LEAK_BIT]                = leak_in;
      sum_data[srd_pkg::END_BIT]                 = end_in;
      sum_data[srd_pkg::COUNT_LSB +: COUNT_BITS] = cnt_in;

      push_b = {1'b1, srd_pkg::KIND_SUMMARY, sum_data};
      push_a = pixel ? {!summary, srd_pkg::KIND_PIXEL, pix_data} : push_b;
      push_count = {1'b0, pixel} + {1'b0, summary};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= 8'd0;
         col_ff  <= 16'd0;
         run_ff  <= 7'd0;
         done_ff <= 1'b1;
         leak_ff <= 1'b0;
         end_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else if (consume) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         run_ff  <= run_in;
         done_ff <= done_in;
         leak_ff <= leak_in;
         end_ff  <= end_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### rtl/srd_rsp_queue.sv
// Small result queue that takes up to two results a cycle and hands out one.
module srd_rsp_queue #(
   parameter int WIDTH = 58
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  logic [WIDTH-1:0] push_a,
   input  logic [WIDTH-1:0] push_b,
   output logic             space_ok,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH = srd_pkg::RSP_QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] tail_next;
   logic             pop;

   always_comb begin
      out_valid = (cnt_ff != '0);
      out_data  = mem_ff[head_ff];
      pop       = out_valid && out_ready;
      // Room for a full pair of results is needed before a word is decoded.
      space_ok  = (cnt_ff <= CNT_W'(DEPTH - 2));
      tail_next = tail_ff + PTR_W'(1);
      head_in   = pop ? head_ff + PTR_W'(1) : head_ff;
      tail_in   = tail_ff + PTR_W'(push_count);
      cnt_in    = cnt_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[tail_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         mem_ff[tail_next] <= push_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
